### rtl/eth_fsd_pkg.sv
// Shared types and constants for the frame subscriber dispatch block.
// No dependencies; imported by every module of the block.
package eth_fsd_pkg;

  localparam logic [1:0]  CMD_FRAME  = 2'd0;
  localparam logic [1:0]  CMD_REG    = 2'd1;
  localparam logic [1:0]  CMD_UNREG  = 2'd2;

  localparam logic [2:0]  OC_DELIVER  = 3'd0;
  localparam logic [2:0]  OC_DROP     = 3'd1;
  localparam logic [2:0]  OC_REG      = 3'd2;
  localparam logic [2:0]  OC_PRESENT  = 3'd3;
  localparam logic [2:0]  OC_FULL     = 3'd4;
  localparam logic [2:0]  OC_REMOVED  = 3'd5;
  localparam logic [2:0]  OC_NOTFOUND = 3'd6;

  localparam logic [31:0] HDR_BYTES   = 32'd14;
  localparam logic [15:0] ETYPE_VLAN  = 16'h8100;
  localparam logic [15:0] ETYPE_PNIO  = 16'h8892;
  localparam logic [47:0] MCAST_ADDR  = 48'h010E_CF00_0001;

  // Fan-out count on the eighth result, the most one multicast frame may produce
  localparam logic [2:0]  FAN_LAST_CNT = 3'd7;

  typedef enum logic [2:0] {
    K_DROP,
    K_MCAST,
    K_UCAST,
    K_REG,
    K_UNREG
  } kind_t;

  typedef struct packed {
    kind_t        kind;
    logic [15:0]  etype;
    logic [10:0]  plen;
    logic [47:0]  key;
  } desc_t;

endpackage

### rtl/eth_fsd_front.sv
// Front end: own-address register with its APB port, and classification of
// incoming items into queue descriptors. Depends on eth_fsd_pkg.
module eth_fsd_front #(
  parameter int MAX_FRAME_BYTES = 1500
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  input  logic [1:0]           cmd,
  input  logic [10:0]          frame_length,
  input  logic [15:0]          ether_type,
  input  logic [47:0]          dest_mac,
  input  logic [47:0]          key_mac,
  output eth_fsd_pkg::desc_t   desc
);
  import eth_fsd_pkg::*;

  logic [47:0] own_mac_r;
  logic [47:0] own_mac_nxt;
  logic [31:0] len_w;
  logic [31:0] len_sat;
  logic        pass;

  always_comb begin
    own_mac_nxt = own_mac_r;
    if (psel && penable && pwrite && !paddr[3]) begin
      own_mac_nxt = pwdata[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r <= '0;
    end else begin
      own_mac_r <= own_mac_nxt;
    end
  end

  assign prdata = paddr[3] ? 64'd0 : {16'd0, own_mac_r};

  // Clip to the receive buffer size before the header checks
  assign len_w   = 32'(frame_length);
  assign len_sat = (len_w > 32'(MAX_FRAME_BYTES)) ? 32'(MAX_FRAME_BYTES) : len_w;
  assign pass    = (len_sat >= HDR_BYTES) &&
                   ((ether_type == ETYPE_VLAN) || (ether_type == ETYPE_PNIO));

  always_comb begin
    desc.etype = ether_type;
    desc.plen  = 11'(len_sat - HDR_BYTES);
    desc.key   = key_mac;
    case (cmd)
      CMD_FRAME: begin
        if (!pass) begin
          desc.kind = K_DROP;
        end else if (dest_mac == MCAST_ADDR) begin
          desc.kind = K_MCAST;
        end else if (dest_mac == own_mac_r) begin
          desc.kind = K_UCAST;
        end else begin
          desc.kind = K_DROP;
        end
      end
      CMD_REG:   desc.kind = K_REG;
      CMD_UNREG: desc.kind = K_UNREG;
      default:   desc.kind = K_DROP;
    endcase
  end

endmodule

### rtl/eth_fsd_fifo.sv
// Two-entry descriptor queue between the classifier and the table engine.
// Depends on eth_fsd_pkg for the descriptor type.
module eth_fsd_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  eth_fsd_pkg::desc_t   wr_desc,
  input  logic                 pop,
  output eth_fsd_pkg::desc_t   rd_desc,
  output logic                 full,
  output logic                 empty
);
  import eth_fsd_pkg::*;

  desc_t       mem_r [2];
  logic        wr_ptr_r;
  logic        wr_ptr_nxt;
  logic        rd_ptr_r;
  logic        rd_ptr_nxt;
  logic [1:0]  count_r;
  logic [1:0]  count_nxt;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rd_desc = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_desc;
    end
  end

endmodule

### rtl/eth_fsd_back.sv
// Table engine: subscriber table, lookup, insert/remove, multicast fan-out
// and the result register. Depends on eth_fsd_pkg.
module eth_fsd_back #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  eth_fsd_pkg::desc_t   head,
  input  logic                 head_empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_outcome,
  output logic [2:0]           out_slot,
  output logic [15:0]          out_frame_type,
  output logic [10:0]          out_payload_length,
  output logic [47:0]          out_source_mac,
  output logic                 out_last
);
  import eth_fsd_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic {ST_IDLE, ST_FAN} state_t;

  state_t                  state_r, state_nxt;
  logic [TABLE_DEPTH-1:0]  valid_r, valid_nxt;
  logic [47:0]             addr_r [TABLE_DEPTH];
  logic                    addr_we;
  logic [IDX_W-1:0]        addr_widx;

  logic [TABLE_DEPTH-1:0]  mask_r, mask_nxt;
  logic [2:0]              cnt_r, cnt_nxt;
  logic [15:0]             fan_etype_r, fan_etype_nxt;
  logic [10:0]             fan_plen_r, fan_plen_nxt;
  logic [47:0]             fan_src_r, fan_src_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [2:0]              out_outcome_r, out_outcome_nxt;
  logic [2:0]              out_slot_r, out_slot_nxt;
  logic [15:0]             out_frame_type_r, out_frame_type_nxt;
  logic [10:0]             out_payload_length_r, out_payload_length_nxt;
  logic [47:0]             out_source_mac_r, out_source_mac_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [TABLE_DEPTH-1:0]  hit_vec;
  logic [TABLE_DEPTH-1:0]  zero_vec;
  logic [TABLE_DEPTH-1:0]  free_vec;
  logic                    out_free;

  function automatic logic [IDX_W-1:0] first_idx(input logic [TABLE_DEPTH-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [2:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+2:0] w;
    w = (IDX_W + 3)'(idx);
    return w[2:0];
  endfunction

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_vec[i]  = valid_r[i] && (addr_r[i] == head.key);
      zero_vec[i] = valid_r[i] && (addr_r[i] == 48'd0);
      free_vec[i] = !valid_r[i];
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt              = state_r;
    valid_nxt              = valid_r;
    mask_nxt               = mask_r;
    cnt_nxt                = cnt_r;
    fan_etype_nxt          = fan_etype_r;
    fan_plen_nxt           = fan_plen_r;
    fan_src_nxt            = fan_src_r;
    out_valid_nxt          = out_valid_r && out_stall;
    out_outcome_nxt        = out_outcome_r;
    out_slot_nxt           = out_slot_r;
    out_frame_type_nxt     = out_frame_type_r;
    out_payload_length_nxt = out_payload_length_r;
    out_source_mac_nxt     = out_source_mac_r;
    out_last_nxt           = out_last_r;
    addr_we                = 1'b0;
    addr_widx              = first_idx(free_vec);
    pop                    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (!head_empty && out_free) begin
          pop                    = 1'b1;
          out_valid_nxt          = 1'b1;
          out_outcome_nxt        = OC_DROP;
          out_slot_nxt           = 3'd0;
          out_frame_type_nxt     = 16'd0;
          out_payload_length_nxt = 11'd0;
          out_source_mac_nxt     = 48'd0;
          out_last_nxt           = 1'b1;
          case (head.kind)
            K_REG: begin
              if (|hit_vec) begin
                out_outcome_nxt = OC_PRESENT;
                out_slot_nxt    = to_slot(first_idx(hit_vec));
              end else if (|free_vec) begin
                valid_nxt[first_idx(free_vec)] = 1'b1;
                addr_we         = 1'b1;
                out_outcome_nxt = OC_REG;
                out_slot_nxt    = to_slot(first_idx(free_vec));
              end else begin
                out_outcome_nxt = OC_FULL;
              end
            end
            K_UNREG: begin
              if (|hit_vec) begin
                valid_nxt[first_idx(hit_vec)] = 1'b0;
                out_outcome_nxt = OC_REMOVED;
                out_slot_nxt    = to_slot(first_idx(hit_vec));
              end else begin
                out_outcome_nxt = OC_NOTFOUND;
              end
            end
            K_UCAST: begin
              // Exact source match first, then the wildcard entry
              if (|hit_vec || |zero_vec) begin
                out_outcome_nxt        = OC_DELIVER;
                out_slot_nxt           = (|hit_vec) ? to_slot(first_idx(hit_vec))
                                                    : to_slot(first_idx(zero_vec));
                out_frame_type_nxt     = head.etype;
                out_payload_length_nxt = head.plen;
                out_source_mac_nxt     = head.key;
              end
            end
            K_MCAST: begin
              if (|valid_r) begin
                // Snapshot valid slots; emit from the fan-out state
                out_valid_nxt = out_valid_r && out_stall;
                state_nxt     = ST_FAN;
                mask_nxt      = valid_r;
                cnt_nxt       = 3'd0;
                fan_etype_nxt = head.etype;
                fan_plen_nxt  = head.plen;
                fan_src_nxt   = head.key;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FAN: begin
        if (out_free) begin
          mask_nxt               = mask_r & (mask_r - TABLE_DEPTH'(1));
          cnt_nxt                = cnt_r + 3'd1;
          out_valid_nxt          = 1'b1;
          out_outcome_nxt        = OC_DELIVER;
          out_slot_nxt           = to_slot(first_idx(mask_r));
          out_frame_type_nxt     = fan_etype_r;
          out_payload_length_nxt = fan_plen_r;
          out_source_mac_nxt     = fan_src_r;
          out_last_nxt           = (mask_nxt == '0) || (cnt_r == FAN_LAST_CNT);
          if (out_last_nxt) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r              <= state_nxt;
      valid_r              <= valid_nxt;
      out_valid_r          <= out_valid_nxt;
      mask_r               <= mask_nxt;
      cnt_r                <= cnt_nxt;
      fan_etype_r          <= fan_etype_nxt;
      fan_plen_r           <= fan_plen_nxt;
      fan_src_r            <= fan_src_nxt;
      out_outcome_r        <= out_outcome_nxt;
      out_slot_r           <= out_slot_nxt;
      out_frame_type_r     <= out_frame_type_nxt;
      out_payload_length_r <= out_payload_length_nxt;
      out_source_mac_r     <= out_source_mac_nxt;
      out_last_r           <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (addr_we) begin
      addr_r[addr_widx] <= head.key;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_outcome        = out_outcome_r;
  assign out_slot           = out_slot_r;
  assign out_frame_type     = out_frame_type_r;
  assign out_payload_length = out_payload_length_r;
  assign out_source_mac     = out_source_mac_r;
  assign out_last           = out_last_r;

endmodule

### rtl/eth_frame_subscriber_dispatch.sv
// Frame subscriber dispatch: a classifier feeding a two-entry queue into a
// table engine that owns the subscriber table and the result register.
// Register, unregister, unicast and dropped items each yield one result from
// the table engine; a multicast frame first snapshots the valid slots and then
// yields one result per valid slot (up to eight results, or one drop result if
// no slot is valid), emitted in ascending slot order. A stalled result holds
// the engine. The queue lets the classifier keep taking items while the engine
// fans out or waits on a stalled result, until the queue is full. own_mac sits
// at APB address 0 (64-bit data).
// Depends on eth_fsd_pkg, eth_fsd_front, eth_fsd_fifo and eth_fsd_back.
module eth_frame_subscriber_dispatch #(
  parameter int TABLE_DEPTH     = 8,
  parameter int MAX_FRAME_BYTES = 1500
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   in_cmd,
  input  logic [10:0]  in_frame_length,
  input  logic [15:0]  in_ether_type,
  input  logic [47:0]  in_dest_mac,
  input  logic [47:0]  in_key_mac,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [2:0]   out_outcome,
  output logic [2:0]   out_slot,
  output logic [15:0]  out_frame_type,
  output logic [10:0]  out_payload_length,
  output logic [47:0]  out_source_mac,
  output logic         out_last
);
  import eth_fsd_pkg::*;

  desc_t  front_desc;
  desc_t  head_desc;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;

  assign pready   = 1'b1;
  assign in_stall = q_full;

  eth_fsd_front #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .cmd          (in_cmd),
    .frame_length (in_frame_length),
    .ether_type   (in_ether_type),
    .dest_mac     (in_dest_mac),
    .key_mac      (in_key_mac),
    .desc         (front_desc)
  );

  eth_fsd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_valid && !q_full),
    .wr_desc (front_desc),
    .pop     (q_pop),
    .rd_desc (head_desc),
    .full    (q_full),
    .empty   (q_empty)
  );

  eth_fsd_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head_desc),
    .head_empty         (q_empty),
    .pop                (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_outcome        (out_outcome),
    .out_slot           (out_slot),
    .out_frame_type     (out_frame_type),
    .out_payload_length (out_payload_length),
    .out_source_mac     (out_source_mac),
    .out_last           (out_last)
  );

endmodule

### test/tb_eth_frame_subscriber_dispatch.sv
`timescale 1ns / 1ps
// Self-checking bench for eth_frame_subscriber_dispatch: directed table then random phases.
// Depends on eth_fsd_pkg and the dispatch RTL; scores results against an in-bench table model.
module tb_eth_frame_subscriber_dispatch;
  import eth_fsd_pkg::*;

  localparam int          TABLE_DEPTH     = 8;
  localparam int          MAX_FRAME_BYTES = 1500;
  localparam int          FAN_CAP         = 8;
  localparam int          POOL_SIZE       = 14;
  localparam int          RAND_PER_PHASE  = 112;
  localparam int          SETTLE_CYCLES   = 8;
  localparam logic [1:0]  CMD_UNKNOWN     = 2'd3;
  localparam logic [47:0] MAC_ONES        = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] OWN_A           = 48'h021A_2B3C_4D5E;
  localparam logic [47:0] FILL_BASE       = 48'h0011_2233_4400;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [10:0] frame_length;
    logic [15:0] ether_type;
    logic [47:0] dest_mac;
    logic [47:0] key_mac;
  } hdr_beat_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [2:0]  slot;
    logic [15:0] frame_type;
    logic [10:0] payload_length;
    logic [47:0] source_mac;
    logic        last;
  } disp_res_t;

  typedef struct {
    hdr_beat_t  beat;
    bit         typed;
    logic [2:0] outcome;
    logic [2:0] slot;
  } drill_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = '0;
  logic [10:0] in_frame_length = '0;
  logic [15:0] in_ether_type = '0;
  logic [47:0] in_dest_mac = '0;
  logic [47:0] in_key_mac = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_outcome;
  logic [2:0]  out_slot;
  logic [15:0] out_frame_type;
  logic [10:0] out_payload_length;
  logic [47:0] out_source_mac;
  logic        out_last;

  // Bench copy of the subscriber table and station address
  logic        sub_valid [TABLE_DEPTH];
  logic [47:0] sub_addr [TABLE_DEPTH];
  logic [47:0] station_mac;

  disp_res_t   dispatch_due[$];
  disp_res_t   fresh_results[$];
  drill_row_t  drill_rows[$];
  logic [47:0] mac_pool [POOL_SIZE];
  int          err_count = 0;
  int          snd_pct = 0;
  int          rcv_pct = 0;

  eth_frame_subscriber_dispatch u_top (
    .clk, .rst_n,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .in_cmd, .in_frame_length, .in_ether_type,
    .in_dest_mac, .in_key_mac,
    .out_valid, .out_stall, .out_outcome, .out_slot, .out_frame_type,
    .out_payload_length, .out_source_mac, .out_last
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("eth_frame_subscriber_dispatch test failed");
    $finish;
  end

  task automatic note_mismatch(input string what, input logic [47:0] got,
                               input logic [47:0] want);
    $display("%0t: %s got %0h want %0h", $time, what, got, want);
    err_count++;
  endtask

  function automatic disp_res_t lone(input logic [2:0] oc, input logic [2:0] slot);
    disp_res_t r;
    r = '0;
    r.outcome = oc;
    r.slot = slot;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic int find_subscriber(input logic [47:0] a);
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (sub_valid[i] && sub_addr[i] == a) return i;
    return -1;
  endfunction

  // Work out the results of one beat into fresh_results and advance the table.
  function automatic void compute_dispatch(input hdr_beat_t b);
    logic [10:0] len;
    disp_res_t   r;
    int          hit;
    fresh_results.delete();
    case (b.cmd)
      CMD_FRAME: begin
        len = b.frame_length;
        if (len > MAX_FRAME_BYTES) len = 11'(MAX_FRAME_BYTES);
        r = '0;
        r.outcome = OC_DELIVER;
        r.frame_type = b.ether_type;
        r.payload_length = 11'(len - HDR_BYTES);
        r.source_mac = b.key_mac;
        if (len >= HDR_BYTES && (b.ether_type == ETYPE_VLAN || b.ether_type == ETYPE_PNIO)) begin
          if (b.dest_mac == MCAST_ADDR) begin
            for (int i = 0; i < TABLE_DEPTH; i++)
              if (sub_valid[i] && fresh_results.size() < FAN_CAP) begin
                r.slot = 3'(i);
                fresh_results.push_back(r);
              end
            if (fresh_results.size() != 0)
              fresh_results[fresh_results.size() - 1].last = 1'b1;
          end else if (b.dest_mac == station_mac) begin
            hit = find_subscriber(b.key_mac);
            if (hit < 0) hit = find_subscriber('0);
            if (hit >= 0) begin
              r.slot = 3'(hit);
              r.last = 1'b1;
              fresh_results.push_back(r);
            end
          end
        end
        if (fresh_results.size() == 0) fresh_results.push_back(lone(OC_DROP, '0));
      end
      CMD_REG: begin
        hit = find_subscriber(b.key_mac);
        if (hit >= 0) begin
          fresh_results.push_back(lone(OC_PRESENT, 3'(hit)));
        end else begin
          for (int i = TABLE_DEPTH - 1; i >= 0; i--)
            if (!sub_valid[i]) hit = i;
          if (hit < 0) begin
            fresh_results.push_back(lone(OC_FULL, '0));
          end else begin
            sub_valid[hit] = 1'b1;
            sub_addr[hit] = b.key_mac;
            fresh_results.push_back(lone(OC_REG, 3'(hit)));
          end
        end
      end
      CMD_UNREG: begin
        hit = find_subscriber(b.key_mac);
        if (hit < 0) begin
          fresh_results.push_back(lone(OC_NOTFOUND, '0));
        end else begin
          sub_valid[hit] = 1'b0;
          fresh_results.push_back(lone(OC_REMOVED, 3'(hit)));
        end
      end
      default: fresh_results.push_back(lone(OC_DROP, '0));
    endcase
  endfunction

  function automatic logic [47:0] rand_mac();
    return 48'({$urandom, $urandom});
  endfunction

  // Mostly well-formed traffic around a small address pool, plus raw noise.
  function automatic hdr_beat_t rand_beat();
    hdr_beat_t b;
    int        pick;
    b.frame_length = 11'($urandom);
    b.ether_type = 16'($urandom);
    b.dest_mac = rand_mac();
    b.key_mac = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      b.cmd = CMD_REG;
    end else if (pick < 30) begin
      b.cmd = CMD_UNREG;
    end else if (pick < 40) begin
      b.cmd = 2'($urandom);
      b.key_mac = rand_mac();
    end else begin
      b.cmd = CMD_FRAME;
      pick = $urandom_range(0, 99);
      if (pick < 85) b.frame_length = 11'($urandom_range(HDR_BYTES, MAX_FRAME_BYTES));
      else if (pick < 93) b.frame_length = 11'($urandom_range(MAX_FRAME_BYTES + 1, 2047));
      else b.frame_length = 11'($urandom_range(0, HDR_BYTES - 1));
      if ($urandom_range(0, 9) != 0) b.ether_type = $urandom_range(0, 1) ? ETYPE_VLAN : ETYPE_PNIO;
      pick = $urandom_range(0, 99);
      if (pick < 40) b.dest_mac = station_mac;
      else if (pick < 75) b.dest_mac = MCAST_ADDR;
      if ($urandom_range(0, 9) < 3) b.key_mac = rand_mac();
    end
    return b;
  endfunction

  task automatic add_row(input logic [1:0] cmd, input logic [10:0] len,
                         input logic [15:0] et, input logic [47:0] dest,
                         input logic [47:0] key, input bit typed,
                         input logic [2:0] oc, input logic [2:0] slot);
    drill_row_t row;
    row.beat = '{cmd, len, et, dest, key};
    row.typed = typed;
    row.outcome = oc;
    row.slot = slot;
    drill_rows.push_back(row);
  endtask

  // Hold a beat on the input until it is taken; random idle cycles ahead of it.
  task automatic present_beat(input hdr_beat_t b);
    while ($urandom_range(0, 99) < snd_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= b.cmd;
    in_frame_length <= b.frame_length;
    in_ether_type <= b.ether_type;
    in_dest_mac <= b.dest_mac;
    in_key_mac <= b.key_mac;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stop sending, wait out every pending result, then let the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (dispatch_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_station_mac(input logic [47:0] v);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= {16'h0, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[47:0] !== v) note_mismatch("own_mac readback", prdata[47:0], v);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    station_mac = v;
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < rcv_pct);

  always @(posedge clk) begin
    disp_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (dispatch_due.size() == 0) begin
        note_mismatch("result with none pending, outcome", 48'(out_outcome), '0);
      end else begin
        want = dispatch_due.pop_front();
        if (out_outcome !== want.outcome)
          note_mismatch("outcome", 48'(out_outcome), 48'(want.outcome));
        if (out_slot !== want.slot)
          note_mismatch("slot", 48'(out_slot), 48'(want.slot));
        if (out_frame_type !== want.frame_type)
          note_mismatch("frame_type", 48'(out_frame_type), 48'(want.frame_type));
        if (out_payload_length !== want.payload_length)
          note_mismatch("payload_length", 48'(out_payload_length), 48'(want.payload_length));
        if (out_source_mac !== want.source_mac)
          note_mismatch("source_mac", out_source_mac, want.source_mac);
        if (out_last !== want.last)
          note_mismatch("last", 48'(out_last), 48'(want.last));
      end
    end
  end

  initial begin
    logic [47:0] own_settings [4];
    hdr_beat_t   b;

    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sub_valid[i] = 1'b0;
      sub_addr[i] = '0;
    end
    station_mac = '0;
    mac_pool[0] = '0;
    mac_pool[1] = MAC_ONES;
    for (int i = 2; i < 8; i++) mac_pool[i] = FILL_BASE + 48'(i);
    for (int i = 8; i < POOL_SIZE; i++) mac_pool[i] = rand_mac();
    own_settings = '{48'h0, MAC_ONES, MCAST_ADDR, rand_mac()};

    // Empty table, unknown command, wildcard and all-ones subscribers
    add_row(CMD_FRAME, 11'd64, ETYPE_VLAN, MCAST_ADDR, 48'h1, 1'b1, OC_DROP, 3'd0);
    add_row(CMD_UNREG, 11'd0, 16'h0, 48'h0, 48'h5, 1'b1, OC_NOTFOUND, 3'd0);
    add_row(CMD_UNKNOWN, 11'h7FF, 16'hFFFF, MAC_ONES, MAC_ONES, 1'b1, OC_DROP, 3'd0);
    add_row(CMD_REG, 11'd0, 16'h0, 48'h0, 48'h0, 1'b1, OC_REG, 3'd0);
    add_row(CMD_REG, 11'd0, 16'h0, 48'h0, MAC_ONES, 1'b1, OC_REG, 3'd1);
    add_row(CMD_REG, 11'd0, 16'h0, 48'h0, MAC_ONES, 1'b1, OC_PRESENT, 3'd1);
    // Length and ethertype gates
    add_row(CMD_FRAME, 11'd13, ETYPE_VLAN, OWN_A, MAC_ONES, 1'b1, OC_DROP, 3'd0);
    add_row(CMD_FRAME, 11'd14, ETYPE_VLAN, OWN_A, MAC_ONES, 1'b0, OC_DELIVER, 3'd0);
    add_row(CMD_FRAME, 11'h7FF, ETYPE_PNIO, OWN_A, 48'hA5A5_5A5A_0F0F, 1'b0, OC_DELIVER, 3'd0);
    add_row(CMD_FRAME, 11'd1500, 16'h8101, OWN_A, MAC_ONES, 1'b1, OC_DROP, 3'd0);
    add_row(CMD_FRAME, 11'd0, 16'h0, 48'h0, 48'h0, 1'b1, OC_DROP, 3'd0);
    add_row(CMD_FRAME, 11'd100, ETYPE_VLAN, OWN_A ^ 48'h1, MAC_ONES, 1'b1, OC_DROP, 3'd0);
    // Fill the table, then overflow it
    for (int i = 2; i < TABLE_DEPTH; i++)
      add_row(CMD_REG, 11'd0, 16'h0, 48'h0, FILL_BASE + 48'(i), 1'b1, OC_REG, 3'(i));
    add_row(CMD_REG, 11'd0, 16'h0, 48'h0, 48'h0BAD_0000_0001, 1'b1, OC_FULL, 3'd0);
    add_row(CMD_FRAME, 11'd1501, ETYPE_PNIO, MCAST_ADDR, 48'h1234, 1'b0, OC_DELIVER, 3'd0);
    // Wildcard gone: unknown source now drops
    add_row(CMD_UNREG, 11'd0, 16'h0, 48'h0, 48'h0, 1'b1, OC_REMOVED, 3'd0);
    add_row(CMD_FRAME, 11'd60, ETYPE_VLAN, OWN_A, 48'h7777, 1'b1, OC_DROP, 3'd0);
    add_row(CMD_FRAME, 11'd60, 16'hFFFF, MCAST_ADDR, 48'h7777, 1'b1, OC_DROP, 3'd0);
    add_row(CMD_UNREG, 11'd0, 16'h0, 48'h0, FILL_BASE + 48'd3, 1'b1, OC_REMOVED, 3'd3);
    add_row(CMD_FRAME, 11'd100, ETYPE_VLAN, MCAST_ADDR, 48'h4242, 1'b0, OC_DELIVER, 3'd0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    snd_pct = 35;
    rcv_pct = 72;
    write_station_mac(OWN_A);

    foreach (drill_rows[k]) begin
      compute_dispatch(drill_rows[k].beat);
      if (drill_rows[k].typed)
        dispatch_due.push_back(lone(drill_rows[k].outcome, drill_rows[k].slot));
      else
        foreach (fresh_results[j]) dispatch_due.push_back(fresh_results[j]);
      present_beat(drill_rows[k].beat);
    end

    for (int ph = 0; ph < 4; ph++) begin
      snd_pct = (ph == 0) ? 35 : (ph == 1) ? 72 : 0;
      rcv_pct = (ph == 0) ? 72 : (ph == 1) ? 35 : 0;
      write_station_mac(own_settings[ph]);
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        // hold off once until the output side is fully caught up
        if (ph == 0 && k == RAND_PER_PHASE / 2) drain();
        b = rand_beat();
        compute_dispatch(b);
        foreach (fresh_results[j]) dispatch_due.push_back(fresh_results[j]);
        present_beat(b);
      end
    end

    drain();
    if (err_count == 0) begin
      $display("eth_frame_subscriber_dispatch test passed");
    end else begin
      $display("eth_frame_subscriber_dispatch test failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/eth_fsd_pkg.sv
rtl/eth_fsd_front.sv
rtl/eth_fsd_fifo.sv
rtl/eth_fsd_back.sv
rtl/eth_frame_subscriber_dispatch.sv
test/tb_eth_frame_subscriber_dispatch.sv
